// ===== hdl/lsb_stego_extractor_assert.svh =====
// Assertion macros for the LSB steganography extractor.
`ifndef LSB_STEGO_EXTRACTOR_ASSERT_SVH
`define LSB_STEGO_EXTRACTOR_ASSERT_SVH

`ifndef SYNTH
// Concurrent property, sampled on the rising clock edge, off while reset is held.
`define LSE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lse assertion failed");
// A condition that must never hold.
`define LSE_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("lse forbidden condition seen");
`else
`define LSE_ASSERT(lbl, clk, rst_n, prop)
`define LSE_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hdl/lse_pkg.sv =====
// Shared types and constants for the LSB steganography extractor.
`default_nettype none

package lse_pkg;

	typedef enum logic [1:0] {
		MODE_LSB1 = 2'd0,
		MODE_LSB4 = 2'd1,
		MODE_LSBI = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	localparam logic [2:0] SLOT_TOP     = 3'd7;
	localparam logic [2:0] FLAG_BYTES   = 3'd4;
	localparam logic [2:0] HEADER_BYTES = 3'd4;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       start_of_image;
		logic       last_of_image;
	} item_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] message_length;
		logic        length_known;
		logic        final_byte;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/lse_in_stage.sv =====
// Input register stage: holds one accepted carrier item for the core.
`default_nettype none

module lse_in_stage (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  lse_pkg::item_t  in_item,
	input  wire             advance,
	output logic            valid_s1,
	output lse_pkg::item_t  item_s1
);
	import lse_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lse_core.sv =====
// Extraction core: running state and the per-item bit placement.
`default_nettype none

module lse_core (
	input  wire               clk,
	input  wire               arst_n,
	input  lse_pkg::mode_t    mode,
	input  lse_pkg::item_t    item,
	input  wire               advance,
	output logic              has_result,
	output lse_pkg::result_t  result
);
	import lse_pkg::*;

	logic [3:0]  flags_q;
	logic [7:0]  asm_q;
	logic [2:0]  slot_q;
	logic [2:0]  hdr_q;
	logic [2:0]  cidx_q;
	logic [31:0] len_q;

	logic [3:0]  flags_e, flags_n;
	logic [7:0]  asm_e, asm_w, asm_n;
	logic [2:0]  slot_e, slot_w, slot_n;
	logic [2:0]  hdr_e, hdr_n;
	logic [2:0]  cidx_e, cidx_n;
	logic [31:0] len_e, len_n;
	logic [3:0]  nib;
	logic        bit_v;
	logic        done;
	logic        emit;

	always_comb begin
		// start of image wipes the running state before this byte is used
		flags_e = item.start_of_image ? 4'd0 : flags_q;
		asm_e   = item.start_of_image ? 8'd0 : asm_q;
		slot_e  = item.start_of_image ? SLOT_TOP : slot_q;
		hdr_e   = item.start_of_image ? 3'd0 : hdr_q;
		cidx_e  = item.start_of_image ? 3'd0 : cidx_q;
		len_e   = item.start_of_image ? 32'd0 : len_q;

		nib     = item.pixel_byte[3:0];
		bit_v   = 1'b0;
		flags_n = flags_e;
		asm_w   = asm_e;
		slot_w  = slot_e;
		done    = 1'b0;

		case (mode)
			MODE_LSB1: begin
				asm_w  = asm_e | (8'(item.pixel_byte[0]) << slot_e);
				done   = (slot_e == 3'd0);
				slot_w = slot_e - 3'd1;
			end
			MODE_LSB4: begin
				// nibble top bit lands on slot; bits below bit 0 are lost
				if (slot_e >= 3'd3) begin
					asm_w = asm_e | (8'(nib) << (slot_e - 3'd3));
				end else begin
					asm_w = asm_e | (8'(nib) >> (3'd3 - slot_e));
				end
				done   = (slot_e < 3'd4);
				slot_w = slot_e - 3'd4;
			end
			MODE_LSBI: begin
				if (cidx_e < FLAG_BYTES) begin
					flags_n[cidx_e[1:0]] = item.pixel_byte[0];
				end else begin
					bit_v  = item.pixel_byte[0] ^ flags_e[item.pixel_byte[2:1]];
					asm_w  = asm_e | (8'(bit_v) << slot_e);
					done   = (slot_e == 3'd0);
					slot_w = slot_e - 3'd1;
				end
			end
			default: begin
			end
		endcase

		cidx_n = (cidx_e < FLAG_BYTES) ? cidx_e + 3'd1 : cidx_e;

		emit = done || (item.last_of_image && (slot_w != SLOT_TOP));

		hdr_n = hdr_e;
		len_n = len_e;
		if (emit) begin
			asm_n  = 8'd0;
			slot_n = SLOT_TOP;
			if (hdr_e < HEADER_BYTES) begin
				len_n = {len_e[23:0], asm_w};
				hdr_n = hdr_e + 3'd1;
			end
		end else begin
			asm_n  = asm_w;
			slot_n = slot_w;
		end

		has_result            = emit;
		result.data_byte      = asm_w;
		result.length_known   = (hdr_n == HEADER_BYTES);
		result.message_length = (hdr_n == HEADER_BYTES) ? len_n : 32'd0;
		result.final_byte     = item.last_of_image;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= 4'd0;
			asm_q   <= 8'd0;
			slot_q  <= SLOT_TOP;
			hdr_q   <= 3'd0;
			cidx_q  <= 3'd0;
			len_q   <= 32'd0;
		end else if (advance) begin
			flags_q <= flags_n;
			asm_q   <= asm_n;
			slot_q  <= slot_n;
			hdr_q   <= hdr_n;
			cidx_q  <= cidx_n;
			len_q   <= len_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lse_out_stage.sv =====
// Result register: holds one recovered byte until the sink takes it.
`default_nettype none

module lse_out_stage (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               load,
	input  lse_pkg::result_t  load_result,
	output logic              free,
	output logic              out_valid,
	input  wire               out_ready,
	output lse_pkg::result_t  out_result
);
	import lse_pkg::*;

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_result <= load_result;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/lsb_stego_extractor.sv =====
// Top level of the LSB steganography extractor.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata pixel_byte, tuser start_of_image,
//                                                 tlast last_of_image
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata data_byte, message_length,
//                                                 tuser length_known, tlast final_byte
//  cfg       in   cfg_we (no back-pressure)       cfg_wdata mode
//
// One carrier item per cycle sustained while no held result stalls the input register. An item
// passes the input register, then the bit placement puts its result into the result register.
// arst_n clears the mode, both stage valid bits and the running extraction state.
// A held result stalls the input register only when the item there makes a result;
// items that give no result keep flowing.
`default_nettype none
`include "lsb_stego_extractor_assert.svh"

module lsb_stego_extractor (
	input  wire         clk,
	input  wire         arst_n,
	// mode register write
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_wdata,      // [1:0] mode
	// carrier items
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] pixel_byte
	input  wire         s_axis_tuser,   // [0] start_of_image
	input  wire         s_axis_tlast,   // last_of_image
	// recovered message items
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [7:0] data_byte, [39:8] message_length
	output logic        m_axis_tuser,   // [0] length_known
	output logic        m_axis_tlast    // final_byte
);
	import lse_pkg::*;

	mode_t    mode_q;
	item_t    in_item;
	item_t    item_s1;
	logic     valid_s1;
	logic     advance;
	logic     has_result;
	logic     out_free;
	logic     out_load;
	result_t  core_result;
	result_t  out_result;

	// mode is to change only while the block is idle; the user must see to it, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LSB1;
		end else if (cfg_we) begin
			mode_q <= mode_t'(cfg_wdata);
		end
	end

	assign in_item.pixel_byte     = s_axis_tdata;
	assign in_item.start_of_image = s_axis_tuser;
	assign in_item.last_of_image  = s_axis_tlast;

	lse_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// the held item moves on unless it has a result and the result register is full
	assign advance  = valid_s1 && (!has_result || out_free);
	assign out_load = advance && has_result;

	lse_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.item       (item_s1),
		.advance    (advance),
		.has_result (has_result),
		.result     (core_result)
	);

	lse_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (out_load),
		.load_result (core_result),
		.free        (out_free),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_result  (out_result)
	);

	assign m_axis_tdata = {out_result.message_length, out_result.data_byte};
	assign m_axis_tuser = out_result.length_known;
	assign m_axis_tlast = out_result.final_byte;

	// a result is only written into a free result register
	`LSE_NEVER(a_load_into_full, clk, arst_n, out_load && m_axis_tvalid && !m_axis_tready)
	// the length stays zero until the header is complete
	`LSE_NEVER(a_len_zero_unknown, clk, arst_n, m_axis_tvalid && !m_axis_tuser && |m_axis_tdata[39:8])
	// a drained input register with nothing new behind it is empty next cycle
	`LSE_ASSERT(a_s1_drains, clk, arst_n, (advance && !(s_axis_tvalid && s_axis_tready)) |=> !valid_s1)
	// nothing is loaded without a held item
	`LSE_NEVER(a_load_without_item, clk, arst_n, out_load && !valid_s1)

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the LSB steganography extractor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lse_pkg::*;

	// One directed stimulus row. An expectation is given only where it is obvious;
	// every other row relies on the predictor.
	typedef struct {
		mode_t      mode;
		logic [7:0] pix;
		logic       sof;
		logic       last;
		bit         typed;
		result_t    want;
	} row_t;

	// Travels with each carrier item from the driver to the acceptance monitor.
	typedef struct {
		bit      typed;
		result_t want;
	} note_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;     // [7:0] pixel_byte
	logic        s_axis_tuser  = 1'b0;   // [0] start_of_image
	logic        s_axis_tlast  = 1'b0;   // last_of_image
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;           // [7:0] data_byte, [39:8] message_length
	logic        m_axis_tuser;           // [0] length_known
	logic        m_axis_tlast;           // final_byte

	lsb_stego_extractor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	// Predictor copy of the mode register and of the running extraction state.
	mode_t       pm_mode = MODE_LSB1;
	logic [3:0]  inv_flags;
	logic [7:0]  asm_byte;
	logic [2:0]  slot;          // next bit position to fill
	logic [2:0]  hdr_seen;      // saturates at HEADER_BYTES
	logic [2:0]  carrier_cnt;   // saturates at FLAG_BYTES
	logic [31:0] len_acc;

	result_t     expected_msgs[$];
	note_t       row_notes[$];
	row_t        carrier_table[$];

	int          errors     = 0;
	int          n_items    = 0;
	int          n_results  = 0;
	int          mode_items[4];
	int          src_idle   = 0;   // percent of cycles the sender holds back
	int          sink_stall = 0;   // percent of cycles the receiver holds back
	int          hold_seq   = 0;   // bumped by the sender to ask for a long hold-off
	int          hold_seen  = 0;
	int          hold_cnt   = 0;

	function void restart_image();
		inv_flags   = '0;
		asm_byte    = '0;
		slot        = SLOT_TOP;
		hdr_seen    = '0;
		carrier_cnt = '0;
		len_acc     = '0;
	endfunction

	// Drop an n-bit group in with its top bit at the current slot; bits that
	// would land below bit 0 are lost. Returns 1 when the byte is full.
	function bit deposit(input logic [7:0] v, input int n);
		int s;
		s = int'(slot);
		if (s >= n - 1) begin
			asm_byte = asm_byte | (v << (s - (n - 1)));
		end else begin
			asm_byte = asm_byte | (v >> ((n - 1) - s));
		end
		if (s < n)
			return 1'b1;
		slot = 3'(s - n);
		return 1'b0;
	endfunction

	// Advance the predictor by one carrier item; returns 1 with the message
	// item in r when one is due.
	function bit extract_step(input logic [7:0] pix, input logic sof, input logic last,
			output result_t r);
		bit         filled;
		logic [7:0] out_b;
		filled = 1'b0;
		r      = '0;
		if (sof)
			restart_image();
		case (pm_mode)
			MODE_LSB1: begin
				filled = deposit({7'd0, pix[0]}, 1);
			end
			MODE_LSB4: begin
				filled = deposit({4'd0, pix[3:0]}, 4);
			end
			MODE_LSBI: begin
				// the first four carrier bytes only load the invert flags
				if (carrier_cnt < FLAG_BYTES)
					inv_flags[carrier_cnt[1:0]] = pix[0];
				else
					filled = deposit({7'd0, pix[0] ^ inv_flags[pix[2:1]]}, 1);
			end
			default: ;
		endcase
		if (carrier_cnt < FLAG_BYTES)
			carrier_cnt = carrier_cnt + 3'd1;
		// flush a partial byte on the last carrier item
		if (!filled && last && slot != SLOT_TOP)
			filled = 1'b1;
		if (!filled)
			return 1'b0;
		out_b    = asm_byte;
		asm_byte = '0;
		slot     = SLOT_TOP;
		if (hdr_seen < HEADER_BYTES) begin
			len_acc  = {len_acc[23:0], out_b};
			hdr_seen = hdr_seen + 3'd1;
		end
		r.data_byte      = out_b;
		r.length_known   = (hdr_seen >= HEADER_BYTES);
		r.message_length = r.length_known ? len_acc : 32'd0;
		r.final_byte     = last;
		return 1'b1;
	endfunction

	task flag_mismatch(input string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	function void add_row(input mode_t m, input logic [7:0] pix, input logic sof,
			input logic last, input bit typed, input logic [7:0] d, input logic [31:0] len,
			input logic known, input logic fin);
		row_t r;
		r.mode                = m;
		r.pix                 = pix;
		r.sof                 = sof;
		r.last                = last;
		r.typed               = typed;
		r.want.data_byte      = d;
		r.want.message_length = len;
		r.want.length_known   = known;
		r.want.final_byte     = fin;
		carrier_table.push_back(r);
	endfunction

	// Acceptance monitor: predicts on every carrier item taken, checks every
	// message item delivered. Both handshakes are sampled at the rising edge.
	always @(posedge clk) begin : watch
		result_t want;
		result_t got;
		note_t   nt;
		bit      due;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				nt  = row_notes.pop_front();
				due = extract_step(s_axis_tdata, s_axis_tuser, s_axis_tlast, want);
				if (due)
					expected_msgs.push_back(nt.typed ? nt.want : want);
				n_items++;
				mode_items[pm_mode]++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.data_byte      = m_axis_tdata[7:0];
				got.message_length = m_axis_tdata[39:8];
				got.length_known   = m_axis_tuser;
				got.final_byte     = m_axis_tlast;
				n_results++;
				if (expected_msgs.size() == 0) begin
					flag_mismatch($sformatf("message item %0d with nothing expected",
						n_results));
				end else begin
					want = expected_msgs.pop_front();
					if (got.data_byte !== want.data_byte)
						flag_mismatch($sformatf("item %0d data_byte %h, want %h",
							n_results, got.data_byte, want.data_byte));
					if (got.message_length !== want.message_length)
						flag_mismatch($sformatf("item %0d message_length %h, want %h",
							n_results, got.message_length, want.message_length));
					if (got.length_known !== want.length_known)
						flag_mismatch($sformatf("item %0d length_known %b, want %b",
							n_results, got.length_known, want.length_known));
					if (got.final_byte !== want.final_byte)
						flag_mismatch($sformatf("item %0d final_byte %b, want %b",
							n_results, got.final_byte, want.final_byte));
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request so that the
	// pipeline fills and back-pressures the carrier side.
	always @(posedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen     <= hold_seq;
			hold_cnt      <= 300;
			m_axis_tready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt      <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_stall);
		end
	end

	// Offer one carrier item, with random idle cycles first; returns at the
	// edge where it is taken, leaving tvalid high.
	task push_carrier(input logic [7:0] pix, input logic sof, input logic last,
			input bit typed, input result_t want);
		note_t nt;
		nt.typed = typed;
		nt.want  = want;
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		row_notes.push_back(nt);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tuser  <= sof;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop offering and wait until every message item is out, then let any
	// item that makes no message clear the two pipeline stages.
	task drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_msgs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mode writes happen only with the block idle.
	task load_mode(input mode_t m);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		pm_mode    = m;
	endtask

	initial begin : stim
		int         img_left;
		int         pick;
		mode_t      m;
		logic [7:0] pix;
		logic       sof;
		logic       last;

		foreach (mode_items[i])
			mode_items[i] = 0;
		restart_image();
		img_left = 0;

		// Directed rows: mode, pixel, start, last, then the obvious result if any.
		// Reset mode, a flush of a single bit, and state kept after the last item.
		add_row(MODE_LSB1, 8'hFF, 1, 1, 1, 8'h80, 32'h0, 0, 1);
		add_row(MODE_LSB1, 8'h00, 0, 1, 1, 8'h00, 32'h0, 0, 1);
		// Four nibble pairs build the length header, known on the fourth byte.
		add_row(MODE_LSB4, 8'h00, 1, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSB4, 8'h00, 0, 0, 1, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSB4, 8'h00, 0, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSB4, 8'h00, 0, 0, 1, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSB4, 8'h00, 0, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSB4, 8'h01, 0, 0, 1, 8'h01, 32'h0, 0, 0);
		add_row(MODE_LSB4, 8'h0F, 0, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSB4, 8'hFF, 0, 0, 1, 8'hFF, 32'h0000_01FF, 1, 0);
		// Unused mode: last with nothing pending gives nothing.
		add_row(MODE_NONE, 8'hAA, 1, 1, 0, 8'h00, 32'h0, 0, 0);
		// Unused mode still flushes a pending bit on last.
		add_row(MODE_LSB1, 8'h01, 1, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_NONE, 8'h00, 0, 1, 1, 8'h80, 32'h0, 0, 1);
		// Mode changes mid-byte; the last nibble loses its low bit.
		add_row(MODE_LSB4, 8'h0A, 1, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSB1, 8'h01, 0, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSB4, 8'h0F, 0, 0, 1, 8'hAF, 32'h0, 0, 0);
		// Inverted scheme: last on a flag byte gives nothing.
		add_row(MODE_LSBI, 8'h01, 1, 1, 0, 8'h00, 32'h0, 0, 0);
		// Flags 1,0,1,0 then five data bits, each flag group hit.
		add_row(MODE_LSBI, 8'h01, 1, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSBI, 8'h00, 0, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSBI, 8'h01, 0, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSBI, 8'h00, 0, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSBI, 8'h00, 0, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSBI, 8'h02, 0, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSBI, 8'h05, 0, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSBI, 8'h07, 0, 0, 0, 8'h00, 32'h0, 0, 0);
		add_row(MODE_LSBI, 8'h00, 0, 1, 1, 8'h98, 32'h0, 0, 1);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (carrier_table[i]) begin
			if (i == 0 || carrier_table[i].mode != pm_mode)
				load_mode(carrier_table[i].mode);
			push_carrier(carrier_table[i].pix, carrier_table[i].sof, carrier_table[i].last,
				carrier_table[i].typed, carrier_table[i].want);
		end

		// Random images in phases; each phase drains, then rewrites the mode.
		// Images run across phase edges, so mode changes land mid-byte too.
		for (int p = 0; p < 12; p++) begin
			if (p < 4) begin
				m = mode_t'(p);
			end else begin
				pick = $urandom_range(9);
				m = (pick < 3) ? MODE_LSB1 : (pick < 6) ? MODE_LSB4 :
					(pick < 9) ? MODE_LSBI : MODE_NONE;
			end
			case (p % 4)
				0: begin src_idle = 0;  sink_stall <= 0;  end
				1: begin src_idle = 57; sink_stall <= 0;  end
				2: begin src_idle = 0;  sink_stall <= 57; end
				default: begin src_idle = 36; sink_stall <= 36; end
			endcase
			if (p == 5) begin
				// back-pressure phase: dense nibble results against a long hold-off
				m          = MODE_LSB4;
				src_idle   = 0;
			end
			load_mode(m);
			if (p == 5)
				hold_seq <= hold_seq + 1;
			repeat (85) begin
				if (img_left == 0) begin
					sof      = 1'b1;
					img_left = ($urandom_range(9) == 0) ? $urandom_range(120, 60) :
						$urandom_range(30, 1);
				end else begin
					// stray start mid-image
					sof = ($urandom_range(39) == 0);
				end
				// stray last mid-image keeps the running state
				last = (img_left == 1) || ($urandom_range(39) == 0);
				img_left--;
				pix = 8'($urandom_range(255));
				push_carrier(pix, sof, last, 1'b0, '0);
			end
		end

		drain();
		repeat (8) @(posedge clk);

		$display("Ran %0d carrier items (LSB1 %0d, LSB4 %0d, LSBI %0d, unused mode %0d),",
			n_items, mode_items[0], mode_items[1], mode_items[2], mode_items[3]);
		$display("checked %0d message items under random idling and one long stall.",
			n_results);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("run limit reached");
		$display("FAILURE");
		$finish;
	end

endmodule
